/* rtl/saw_pkg.sv */
package saw_pkg;

  // Event codes carried on the mode field
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_PKT  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // Configuration register indexes
  localparam logic CFG_IDX_TIMEOUT = 1'b0;
  localparam logic CFG_IDX_DLV_LIM = 1'b1;

  localparam logic [15:0] TIMEOUT_RST   = 16'd300;
  localparam logic [10:0] DLV_LIMIT_RST = 11'd1024;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_NONE      = 4'd0,
    ST_SENT      = 4'd1,
    ST_TO_RESEND = 4'd2,
    ST_BAD_RESEND = 4'd3,
    ST_ACKED     = 4'd4,
    ST_DELIVERED = 4'd5,
    ST_REACKED   = 4'd6,
    ST_OVERSIZE  = 4'd7,
    ST_BUSY      = 4'd8
  } status_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [10:0] deliver_limit;
  } saw_cfg_t;

  typedef struct packed {
    logic        send_bit;
    logic        recv_bit;
    logic        waiting;
    logic [15:0] elapsed_ticks;
    logic [10:0] held_size;
    logic [7:0]  held_tag;
  } saw_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] send_size;
    logic [7:0]  send_tag;
    logic        pkt_corrupt;
    logic        pkt_is_ack;
    logic        pkt_seq;
    logic [10:0] pkt_size;
    logic [7:0]  pkt_tag;
  } saw_evt_t;

  typedef struct packed {
    logic        tx_valid;
    logic        tx_is_ack;
    logic        tx_seq;
    logic [10:0] tx_size;
    logic [7:0]  tx_tag;
    logic        deliver_valid;
    logic [10:0] deliver_size;
    logic [7:0]  deliver_tag;
    status_t     status;
    logic        awaiting_ack;
  } saw_res_t;

endpackage

/* rtl/saw_step.sv */
module saw_step #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  saw_pkg::saw_cfg_t   cfg,
  input  saw_pkg::saw_state_t state,
  input  saw_pkg::saw_evt_t   evt,
  output saw_pkg::saw_state_t state_nxt,
  output saw_pkg::saw_res_t   res
);
  import saw_pkg::*;

  localparam logic [16:0] MAX_PL = 17'(MAX_PAYLOAD);

  logic        send_big;
  logic        pkt_big;
  logic        reply_bad;
  logic        data_bad;
  logic [15:0] ticks_inc;

  // Size checks and reply classification
  assign send_big  = {6'd0, evt.send_size} > MAX_PL;
  assign pkt_big   = (evt.pkt_size > cfg.deliver_limit) || ({6'd0, evt.pkt_size} > MAX_PL);
  assign reply_bad = evt.pkt_corrupt || !evt.pkt_is_ack || (evt.pkt_seq != state.send_bit);
  assign data_bad  = evt.pkt_corrupt || evt.pkt_is_ack || (evt.pkt_seq != state.recv_bit);
  // saturating tick count
  assign ticks_inc = (state.elapsed_ticks < TICKS_MAX) ? state.elapsed_ticks + 16'd1
                                                       : state.elapsed_ticks;

  // Sender and receiver rules for one event
  always_comb begin
    state_nxt = state;
    res       = '0;
    res.status = ST_NONE;
    case (evt.mode)
      MODE_SEND: begin
        if (state.waiting) begin
          res.status = ST_BUSY;
        end else if (send_big) begin
          res.status = ST_OVERSIZE;
        end else begin
          state_nxt.held_size     = evt.send_size;
          state_nxt.held_tag      = evt.send_tag;
          state_nxt.waiting       = 1'b1;
          state_nxt.elapsed_ticks = '0;
          res.tx_valid = 1'b1;
          res.tx_seq   = state.send_bit;
          res.tx_size  = evt.send_size;
          res.tx_tag   = evt.send_tag;
          res.status   = ST_SENT;
        end
      end
      MODE_PKT: begin
        if (state.waiting) begin
          if (reply_bad) begin
            // resend held data, timer keeps running
            res.tx_valid = 1'b1;
            res.tx_seq   = state.send_bit;
            res.tx_size  = state.held_size;
            res.tx_tag   = state.held_tag;
            res.status   = ST_BAD_RESEND;
          end else begin
            state_nxt.send_bit      = ~state.send_bit;
            state_nxt.waiting       = 1'b0;
            state_nxt.elapsed_ticks = '0;
            res.status = ST_ACKED;
          end
        end else begin
          if (data_bad) begin
            res.tx_valid  = 1'b1;
            res.tx_is_ack = 1'b1;
            res.tx_seq    = ~state.recv_bit;
            res.status    = ST_REACKED;
          end else if (pkt_big) begin
            res.status = ST_OVERSIZE;
          end else begin
            state_nxt.recv_bit = ~state.recv_bit;
            res.tx_valid      = 1'b1;
            res.tx_is_ack     = 1'b1;
            res.tx_seq        = state.recv_bit;
            res.deliver_valid = 1'b1;
            res.deliver_size  = evt.pkt_size;
            res.deliver_tag   = evt.pkt_tag;
            res.status        = ST_DELIVERED;
          end
        end
      end
      MODE_TICK: begin
        if (state.waiting) begin
          state_nxt.elapsed_ticks = ticks_inc;
          if (ticks_inc >= cfg.timeout_ticks) begin
            state_nxt.elapsed_ticks = '0;
            res.tx_valid = 1'b1;
            res.tx_seq   = state.send_bit;
            res.tx_size  = state.held_size;
            res.tx_tag   = state.held_tag;
            res.status   = ST_TO_RESEND;
          end
        end
      end
      default: begin
        res.status = ST_NONE;
      end
    endcase
    res.awaiting_ack = state_nxt.waiting;
  end

endmodule

/* rtl/stop_and_wait_endpoint_core.sv */
// Pipeline: an accepted event is registered in evt_r and its result in res_r,
// which drives the result port. Throughput: one event per cycle unless
// out_ready stalls; the endpoint state updates in the same cycle the result
// register loads, so back-to-back events see fresh state.
// Reset (rst_n low, synchronous): sequence bits, waiting flag, tick counter
// and both pipeline valids clear; timeout_ticks = 300, deliver_limit = 1024.
module stop_and_wait_endpoint_core #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata,
  // event input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [10:0] in_send_size,
  input  logic [7:0]  in_send_tag,
  input  logic        in_pkt_corrupt,
  input  logic        in_pkt_is_ack,
  input  logic        in_pkt_seq,
  input  logic [10:0] in_pkt_size,
  input  logic [7:0]  in_pkt_tag,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic        out_tx_is_ack,
  output logic        out_tx_seq,
  output logic [10:0] out_tx_size,
  output logic [7:0]  out_tx_tag,
  output logic        out_deliver_valid,
  output logic [10:0] out_deliver_size,
  output logic [7:0]  out_deliver_tag,
  output logic [3:0]  out_status,
  output logic        out_awaiting_ack
);
  import saw_pkg::*;

  saw_cfg_t   cfg_r;
  saw_state_t state_r;
  saw_state_t state_nxt;
  saw_evt_t   evt_r;
  saw_res_t   res_r;
  saw_res_t   res_nxt;
  logic       in_vld_r;
  logic       out_vld_r;
  logic       step_go;

  // Input stage advances whenever the result register is free or draining
  assign step_go  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step_go;

  saw_step #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .evt       (evt_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  // Control state, configuration and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.deliver_limit <= DLV_LIMIT_RST;
      state_r   <= '0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_IDX_TIMEOUT: cfg_r.timeout_ticks <= cfg_wdata;
          CFG_IDX_DLV_LIM: cfg_r.deliver_limit <= cfg_wdata[10:0];
        endcase
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (step_go) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      evt_r.mode        <= in_mode;
      evt_r.send_size   <= in_send_size;
      evt_r.send_tag    <= in_send_tag;
      evt_r.pkt_corrupt <= in_pkt_corrupt;
      evt_r.pkt_is_ack  <= in_pkt_is_ack;
      evt_r.pkt_seq     <= in_pkt_seq;
      evt_r.pkt_size    <= in_pkt_size;
      evt_r.pkt_tag     <= in_pkt_tag;
    end
    if (step_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_tx_valid      = res_r.tx_valid;
  assign out_tx_is_ack     = res_r.tx_is_ack;
  assign out_tx_seq        = res_r.tx_seq;
  assign out_tx_size       = res_r.tx_size;
  assign out_tx_tag        = res_r.tx_tag;
  assign out_deliver_valid = res_r.deliver_valid;
  assign out_deliver_size  = res_r.deliver_size;
  assign out_deliver_tag   = res_r.deliver_tag;
  assign out_status        = res_r.status;
  assign out_awaiting_ack  = res_r.awaiting_ack;

  // A delivery is always answered with an ACK in the same result
  a_dlv_acked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deliver_valid |-> out_tx_valid && out_tx_is_ack)
    else $error("delivery without ACK");

  // A fresh send leaves a data packet outstanding
  a_sent_waits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SENT) |-> out_awaiting_ack && out_tx_valid && !out_tx_is_ack)
    else $error("send did not start waiting");

  // A correct ACK ends the wait
  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ACKED) |-> !out_awaiting_ack && !out_tx_valid)
    else $error("ACK left block waiting");

  // A busy refusal transmits nothing and only happens while waiting
  a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BUSY) |-> out_awaiting_ack && !out_tx_valid)
    else $error("busy refusal transmitted");

endmodule

/* tb/saw_reply_checker.sv */
`timescale 1ns / 1ps

module saw_reply_checker #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [10:0] in_send_size,
  input  logic [7:0]  in_send_tag,
  input  logic        in_pkt_corrupt,
  input  logic        in_pkt_is_ack,
  input  logic        in_pkt_seq,
  input  logic [10:0] in_pkt_size,
  input  logic [7:0]  in_pkt_tag,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_tx_valid,
  input  logic        out_tx_is_ack,
  input  logic        out_tx_seq,
  input  logic [10:0] out_tx_size,
  input  logic [7:0]  out_tx_tag,
  input  logic        out_deliver_valid,
  input  logic [10:0] out_deliver_size,
  input  logic [7:0]  out_deliver_tag,
  input  logic [3:0]  out_status,
  input  logic        out_awaiting_ack,
  output int          mismatches,
  output int          replies_outstanding,
  output logic        pred_waiting,
  output logic        pred_send_bit,
  output logic        pred_recv_bit
);
  import saw_pkg::*;

  // Shadow copy of the endpoint registers and configuration
  logic        tx_seq_bit;
  logic        rx_seq_bit;
  logic        awaiting;
  logic [15:0] tick_count;
  logic [10:0] held_size;
  logic [7:0]  held_tag;
  logic [15:0] cfg_timeout;
  logic [10:0] cfg_dlv_limit;

  saw_res_t replies_due[$];
  saw_evt_t evt_in;

  assign evt_in = '{mode: in_mode, send_size: in_send_size, send_tag: in_send_tag,
                    pkt_corrupt: in_pkt_corrupt, pkt_is_ack: in_pkt_is_ack,
                    pkt_seq: in_pkt_seq, pkt_size: in_pkt_size, pkt_tag: in_pkt_tag};

  assign pred_waiting  = awaiting;
  assign pred_send_bit = tx_seq_bit;
  assign pred_recv_bit = rx_seq_bit;

  // Held data packet, as sent or resent
  function automatic saw_res_t data_frame();
    saw_res_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_is_ack = 1'b0;
    r.tx_seq = tx_seq_bit;
    r.tx_size = held_size;
    r.tx_tag = held_tag;
    return r;
  endfunction

  // Advance the shadow endpoint by one event and return the reply it gives
  function automatic saw_res_t endpoint_react(input saw_evt_t e);
    saw_res_t r;
    r = '0;
    r.status = ST_NONE;
    case (e.mode)
      MODE_SEND: begin
        if (awaiting) begin
          r.status = ST_BUSY;
        end else if (e.send_size > MAX_PAYLOAD) begin
          r.status = ST_OVERSIZE;
        end else begin
          held_size = e.send_size;
          held_tag = e.send_tag;
          awaiting = 1'b1;
          tick_count = '0;
          r = data_frame();
          r.status = ST_SENT;
        end
      end
      MODE_PKT: begin
        if (awaiting) begin
          // sender side: anything but a clean ACK of our bit triggers a resend
          if (e.pkt_corrupt || !e.pkt_is_ack || e.pkt_seq != tx_seq_bit) begin
            r = data_frame();
            r.status = ST_BAD_RESEND;
          end else begin
            tx_seq_bit = ~tx_seq_bit;
            awaiting = 1'b0;
            tick_count = '0;
            r.status = ST_ACKED;
          end
        end else if (e.pkt_corrupt || e.pkt_is_ack || e.pkt_seq != rx_seq_bit) begin
          r.tx_valid = 1'b1;
          r.tx_is_ack = 1'b1;
          r.tx_seq = ~rx_seq_bit;
          r.status = ST_REACKED;
        end else if (e.pkt_size > cfg_dlv_limit || e.pkt_size > MAX_PAYLOAD) begin
          r.status = ST_OVERSIZE;
        end else begin
          r.tx_valid = 1'b1;
          r.tx_is_ack = 1'b1;
          r.tx_seq = rx_seq_bit;
          r.deliver_valid = 1'b1;
          r.deliver_size = e.pkt_size;
          r.deliver_tag = e.pkt_tag;
          r.status = ST_DELIVERED;
          rx_seq_bit = ~rx_seq_bit;
        end
      end
      MODE_TICK: begin
        if (awaiting) begin
          if (tick_count < TICKS_MAX) tick_count++;
          if (tick_count >= cfg_timeout) begin
            tick_count = '0;
            r = data_frame();
            r.status = ST_TO_RESEND;
          end
        end
      end
      default: ;
    endcase
    r.awaiting_ack = awaiting;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Config writes, accepted events and result transfers, all at the rising edge
  always @(posedge clk) begin
    saw_res_t want;
    if (!rst_n) begin
      tx_seq_bit = 1'b0;
      rx_seq_bit = 1'b0;
      awaiting = 1'b0;
      tick_count = '0;
      held_size = '0;
      held_tag = '0;
      cfg_timeout = TIMEOUT_RST;
      cfg_dlv_limit = DLV_LIMIT_RST;
      replies_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_IDX_TIMEOUT) cfg_timeout = cfg_wdata;
        else cfg_dlv_limit = cfg_wdata[10:0];
      end
      if (in_valid && in_ready) replies_due.push_back(endpoint_react(evt_in));
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with nothing predicted: status %0d", out_status);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("tx_valid", want.tx_valid, out_tx_valid);
          check_field("tx_is_ack", want.tx_is_ack, out_tx_is_ack);
          check_field("tx_seq", want.tx_seq, out_tx_seq);
          check_field("tx_size", want.tx_size, out_tx_size);
          check_field("tx_tag", want.tx_tag, out_tx_tag);
          check_field("deliver_valid", want.deliver_valid, out_deliver_valid);
          check_field("deliver_size", want.deliver_size, out_deliver_size);
          check_field("deliver_tag", want.deliver_tag, out_deliver_tag);
          check_field("status", want.status, out_status);
          check_field("awaiting_ack", want.awaiting_ack, out_awaiting_ack);
        end
      end
    end
    replies_outstanding = replies_due.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import saw_pkg::*;

  localparam int MAX_PAYLOAD = 1024;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [10:0] in_send_size = '0;
  logic [7:0]  in_send_tag = '0;
  logic        in_pkt_corrupt = 1'b0;
  logic        in_pkt_is_ack = 1'b0;
  logic        in_pkt_seq = 1'b0;
  logic [10:0] in_pkt_size = '0;
  logic [7:0]  in_pkt_tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_tx_valid;
  logic        out_tx_is_ack;
  logic        out_tx_seq;
  logic [10:0] out_tx_size;
  logic [7:0]  out_tx_tag;
  logic        out_deliver_valid;
  logic [10:0] out_deliver_size;
  logic [7:0]  out_deliver_tag;
  logic [3:0]  out_status;
  logic        out_awaiting_ack;

  int   mismatches;
  int   replies_outstanding;
  logic pred_waiting;
  logic pred_send_bit;
  logic pred_recv_bit;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  stop_and_wait_endpoint_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) uut (.*);
  saw_reply_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) reply_chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side back-pressure
  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic saw_evt_t mk_evt(input logic [1:0] mode, input logic [10:0] ssize,
                                      input logic [7:0] stag, input logic bad,
                                      input logic ack, input logic seq,
                                      input logic [10:0] psize, input logic [7:0] ptag);
    return '{mode: mode, send_size: ssize, send_tag: stag, pkt_corrupt: bad,
             pkt_is_ack: ack, pkt_seq: seq, pkt_size: psize, pkt_tag: ptag};
  endfunction

  // Sizes weighted towards the limits, with some beyond the payload maximum
  function automatic logic [10:0] random_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return 11'(MAX_PAYLOAD);
    if (pick < 14) return '0;
    if (pick < 24) return 11'($urandom_range(2047, MAX_PAYLOAD + 1));
    return 11'($urandom_range(MAX_PAYLOAD, 0));
  endfunction

  // Mostly well-formed protocol traffic for the current endpoint state
  function automatic saw_evt_t random_event();
    saw_evt_t e;
    int unsigned pick;
    int unsigned flaw;
    e.send_size = random_size();
    e.send_tag = 8'($urandom);
    e.pkt_corrupt = 1'($urandom);
    e.pkt_is_ack = 1'($urandom);
    e.pkt_seq = 1'($urandom);
    e.pkt_size = random_size();
    e.pkt_tag = 8'($urandom);
    e.mode = MODE_PKT;
    pick = $urandom_range(99);
    flaw = $urandom_range(9);
    if (pred_waiting) begin
      if (pick < 40) begin
        // reply to the outstanding data, usually a clean ACK
        e.pkt_corrupt = (flaw == 0);
        e.pkt_is_ack = (flaw != 1);
        e.pkt_seq = pred_send_bit ^ (flaw == 2);
      end else if (pick < 80) begin
        e.mode = MODE_TICK;
      end else if (pick < 88) begin
        e.mode = MODE_SEND;
      end else if (pick < 93) begin
        e.mode = MODE_UNUSED;
      end
    end else begin
      if (pick < 35) begin
        e.mode = MODE_SEND;
      end else if (pick < 75) begin
        // incoming data, usually in order and clean
        e.pkt_corrupt = (flaw == 0);
        e.pkt_is_ack = (flaw == 1);
        e.pkt_seq = pred_recv_bit ^ (flaw == 2);
      end else if (pick < 88) begin
        e.mode = MODE_TICK;
      end else if (pick < 93) begin
        e.mode = MODE_UNUSED;
      end
    end
    return e;
  endfunction

  // One event transfer, with optional idle cycles in front
  task automatic drive_event(input saw_evt_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= e.mode;
    in_send_size <= e.send_size;
    in_send_tag <= e.send_tag;
    in_pkt_corrupt <= e.pkt_corrupt;
    in_pkt_is_ack <= e.pkt_is_ack;
    in_pkt_seq <= e.pkt_seq;
    in_pkt_size <= e.pkt_size;
    in_pkt_tag <= e.pkt_tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every reply is back and the pipeline is empty
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (replies_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] timeout, input logic [15:0] limit_word,
                           input int idle, input int stall, input int n);
    saw_evt_t e;
    int counted;
    drain_replies();
    write_cfg(CFG_IDX_TIMEOUT, timeout);
    write_cfg(CFG_IDX_DLV_LIM, limit_word);
    send_idle_pct = idle;
    stall_pct = stall;
    // two halves, with a full drain between them
    for (int half = 0; half < 2; half++) begin
      counted = 0;
      while (counted < n / 2) begin
        e = random_event();
        counted++;
        drive_event(e);
      end
      drain_replies();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: receiver side at reset configuration
    drive_event(mk_evt(MODE_TICK, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_UNUSED, 11'd2047, 8'd255, 1'b1, 1'b1, 1'b1, 11'd2047, 8'd255));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0, 11'd1024, 8'd255));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0, 11'd5, 8'd1));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b0, 1'b0, 1'b1, 11'd1025, 8'd7));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b0, 1'b1, 1'b1, 11'd9, 8'd9));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b1, 1'b0, 1'b1, 11'd9, 8'd9));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b0, 1'b0, 1'b1, 11'd0, 8'd0));
    // sender side: oversize, send, busy, bad replies, clean ACK
    drive_event(mk_evt(MODE_SEND, 11'd2047, 8'd255, 1'b0, 1'b0, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_SEND, 11'd1024, 8'd255, 1'b0, 1'b0, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_SEND, 11'd3, 8'd3, 1'b0, 1'b0, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b1, 1'b1, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0, 11'd4, 8'd4));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b0, 1'b1, 1'b1, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_TICK, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_UNUSED, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b0, 1'b1, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_SEND, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0, 11'd0, 8'd0));
    // short timeout: second tick resends, then ACK
    drain_replies();
    write_cfg(CFG_IDX_TIMEOUT, 16'd2);
    drive_event(mk_evt(MODE_TICK, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_TICK, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_TICK, 11'd0, 8'd0, 1'b0, 1'b0, 1'b0, 11'd0, 8'd0));
    drive_event(mk_evt(MODE_PKT, 11'd0, 8'd0, 1'b0, 1'b1, 1'b1, 11'd0, 8'd0));

    // Random phases over settings and idling patterns
    run_phase(16'd3, 16'd1024, 0, 0, 200);
    run_phase(16'd1, 16'd0, 80, 0, 150);
    run_phase(16'd0, 16'd2047, 0, 80, 150);
    run_phase(16'hFFFF, 16'd512, 17, 17, 150);
    run_phase(16'd2, 16'd1, 0, 0, 200);
    run_phase(16'($urandom_range(6, 1)), {5'($urandom), 11'($urandom_range(2047, 0))},
              80, 0, 150);
    run_phase(16'($urandom_range(12, 1)), 16'($urandom_range(1024, 0)), 0, 80, 150);
    run_phase(TIMEOUT_RST, 16'(DLV_LIMIT_RST), 17, 17, 200);

    drain_replies();
    if (mismatches == 0 && replies_outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
